### rtl/pft_pkg.sv
`default_nettype none

package pft_pkg;

  // Table geometry
  localparam int FRAMES     = 128;
  localparam int OWNER_BITS = 8;
  localparam int PAGE_BITS  = 10;
  localparam int NEED_W     = 8;
  localparam int IDX_W      = $clog2(FRAMES);
  localparam int CNT_W      = $clog2(FRAMES + 1);

  // Request operation codes
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_TEST   = 2'd3
  } pft_op_t;

  // One request transaction
  typedef struct packed {
    pft_op_t               operation;
    logic [OWNER_BITS-1:0] owner_id;
    logic [PAGE_BITS-1:0]  page_number;
    logic [NEED_W-1:0]     need_count;
  } pft_in_t;

  // One result transaction
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] frame_index;
    logic [CNT_W-1:0] tally;
  } pft_out_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic             act;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] tally;
  } pft_carry_t;

endpackage

`default_nettype wire

### rtl/page_frame_table_top.sv
`default_nettype none

// Page frame table: FRAMES frames, each holding a valid mark, owner id and
// page number, all free after reset. A transaction is accepted when start is
// high and busy is low; busy then stays high until the result appears. The
// request is held for the whole operation while a scan token walks the row of
// frame cells, one cell per cycle, so the row length sets how long each
// transaction takes from accept to the next possible accept. The result is
// shown for exactly one cycle with out_valid high, in the cycle busy drops;
// the receiver cannot stall it and must take it then. Lookup and allocate
// report the lowest matching or free frame; tally is the free frame count
// after the operation, or for a free-by-owner the number of frames released.
module page_frame_table_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire pft_pkg::pft_in_t in_data,
  output logic                  out_valid,
  output pft_pkg::pft_out_t     out_data
);

  logic                busy_r;
  logic                accept;
  pft_pkg::pft_in_t    req_r;
  logic                head_act_r;
  pft_pkg::pft_carry_t chain [pft_pkg::FRAMES+1];
  pft_pkg::pft_carry_t tail;
  logic                out_valid_r;
  pft_pkg::pft_out_t   out_data_r, res_nxt;

  assign accept = start && !busy_r;

  // Token launched into the first cell
  assign chain[0] = '{act: head_act_r, found: 1'b0, idx: '0, tally: '0};

  // Row of frame cells
  for (genvar g = 0; g < pft_pkg::FRAMES; g++) begin : g_cell
    pft_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (pft_pkg::IDX_W'(g)),
      .req      (req_r),
      .carry_in (chain[g]),
      .carry_out(chain[g+1])
    );
  end

  assign tail = chain[pft_pkg::FRAMES];

  // Result from the token leaving the last cell
  always_comb begin
    res_nxt.frame_index = tail.idx;
    res_nxt.tally       = tail.tally;
    case (req_r.operation)
      pft_pkg::OP_LOOKUP: res_nxt.hit = tail.found;
      pft_pkg::OP_ALLOC:  res_nxt.hit = tail.found;
      pft_pkg::OP_FREE:   res_nxt.hit = (tail.tally != '0);
      pft_pkg::OP_TEST:   res_nxt.hit = (16'(tail.tally) >= 16'(req_r.need_count));
      default:            res_nxt.hit = 1'b0;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      head_act_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_act_r  <= accept;
      out_valid_r <= tail.act;
      if (accept)        busy_r <= 1'b1;
      else if (tail.act) busy_r <= 1'b0;
    end
  end

  // Request hold and result register
  always_ff @(posedge clk) begin
    if (accept)   req_r      <= in_data;
    if (tail.act) out_data_r <= res_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/pft_cell.sv
`default_nettype none

// One frame of the table. The scan token is registered here on its way to the
// next frame; the frame applies the request when the token is active.
module pft_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [pft_pkg::IDX_W-1:0] cell_idx,
  input  wire pft_pkg::pft_in_t       req,
  input  wire pft_pkg::pft_carry_t    carry_in,
  output pft_pkg::pft_carry_t         carry_out
);

  logic                           valid_r, valid_nxt;
  logic [pft_pkg::OWNER_BITS-1:0] owner_r;
  logic [pft_pkg::PAGE_BITS-1:0]  page_r;
  logic                           wr_en;
  logic                           owner_match;
  logic                           page_match;
  pft_pkg::pft_carry_t            carry_r, carry_nxt;

  assign owner_match = valid_r && (owner_r == req.owner_id);
  assign page_match  = owner_match && (page_r == req.page_number);

  // Apply the request to this frame and update the token
  always_comb begin
    carry_nxt = carry_in;
    valid_nxt = valid_r;
    wr_en     = 1'b0;
    if (carry_in.act) begin
      case (req.operation)
        pft_pkg::OP_LOOKUP: begin
          if (page_match && !carry_in.found) begin
            carry_nxt.found = 1'b1;
            carry_nxt.idx   = cell_idx;
          end
          if (!valid_r) carry_nxt.tally = carry_in.tally + pft_pkg::CNT_W'(1);
        end
        pft_pkg::OP_ALLOC: begin
          if (!valid_r && !carry_in.found) begin
            // lowest free frame claims the request
            valid_nxt       = 1'b1;
            wr_en           = 1'b1;
            carry_nxt.found = 1'b1;
            carry_nxt.idx   = cell_idx;
          end else if (!valid_r) begin
            carry_nxt.tally = carry_in.tally + pft_pkg::CNT_W'(1);
          end
        end
        pft_pkg::OP_FREE: begin
          if (owner_match) begin
            valid_nxt       = 1'b0;
            carry_nxt.tally = carry_in.tally + pft_pkg::CNT_W'(1);
          end
        end
        pft_pkg::OP_TEST: begin
          if (!valid_r) carry_nxt.tally = carry_in.tally + pft_pkg::CNT_W'(1);
        end
        default: begin
          carry_nxt = carry_in;
        end
      endcase
    end
  end

  // Control state and token register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      carry_r <= carry_nxt;
    end
  end

  // Frame contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_r <= req.owner_id;
      page_r  <= req.page_number;
    end
  end

  assign carry_out = carry_r;

endmodule

`default_nettype wire

### rtl/pft_checker.sv
`default_nettype none

// Port-level checks on the page frame table
module pft_props (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire pft_pkg::pft_out_t out_data
);

  // An accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held more than one cycle");

  // The result appears exactly when busy drops
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A miss reports frame zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.frame_index == '0)
    else $error("nonzero frame index on miss");

endmodule

bind page_frame_table_top pft_props u_pft_props (.*);

`default_nettype wire

### test/pft_checker.sv
module pft_checker
  import pft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire pft_in_t  in_data,
  input  wire logic     out_valid,
  input  wire pft_out_t out_data,
  output int            fail_count,
  output int            pending,
  output int            checked,
  output logic          full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the frame table
  logic                  frame_used [FRAMES];
  logic [OWNER_BITS-1:0] frame_pid  [FRAMES];
  logic [PAGE_BITS-1:0]  frame_vpn  [FRAMES];

  pft_out_t expected_q[$];
  int       fails = 0;
  int       results = 0;
  logic     saw_full = 1'b0;

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
    full_seen  = 1'b0;
  end

  function automatic int free_frames();
    int n;
    n = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!frame_used[i]) n++;
    end
    return n;
  endfunction

  // Apply one request to the shadow table and return the result it must give
  function automatic pft_out_t predict_frame_op(pft_in_t req);
    pft_out_t res;
    int       freed;
    res   = '0;
    freed = 0;
    case (req.operation)
      OP_LOOKUP: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i] && frame_pid[i] == req.owner_id &&
              frame_vpn[i] == req.page_number) begin
            res.hit         = 1'b1;
            res.frame_index = IDX_W'(i);
            break;
          end
        end
        res.tally = CNT_W'(free_frames());
      end
      OP_ALLOC: begin
        // lowest free frame wins, duplicates are not checked
        for (int i = 0; i < FRAMES; i++) begin
          if (!frame_used[i]) begin
            frame_used[i]   = 1'b1;
            frame_pid[i]    = req.owner_id;
            frame_vpn[i]    = req.page_number;
            res.hit         = 1'b1;
            res.frame_index = IDX_W'(i);
            break;
          end
        end
        res.tally = CNT_W'(free_frames());
      end
      OP_FREE: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i] && frame_pid[i] == req.owner_id) begin
            frame_used[i] = 1'b0;
            frame_pid[i]  = '0;
            frame_vpn[i]  = '0;
            freed++;
          end
        end
        res.tally = CNT_W'(freed);
        res.hit   = (freed != 0);
      end
      default: begin
        res.tally = CNT_W'(free_frames());
        res.hit   = (free_frames() >= int'(req.need_count));
      end
    endcase
    return res;
  endfunction

  task automatic report(input string what, input logic [15:0] got,
                        input logic [15:0] want);
    $display("checker: %s wrong on result %0d: got %0d, expected %0d",
             what, results, got, want);
    fails++;
  endtask

  // Retire results first, then record a new transaction taken at the same edge
  always @(posedge clk) begin : monitor
    pft_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_used[i] = 1'b0;
        frame_pid[i]  = '0;
        frame_vpn[i]  = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_q.size() == 0) begin
          report("unrequested result", 16'(out_data), 16'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_data.hit !== want.hit)
            report("hit", 16'(out_data.hit), 16'(want.hit));
          if (out_data.frame_index !== want.frame_index)
            report("frame_index", 16'(out_data.frame_index), 16'(want.frame_index));
          if (out_data.tally !== want.tally)
            report("tally", 16'(out_data.tally), 16'(want.tally));
          results++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        want = predict_frame_op(in_data);
        expected_q.push_back(want);
        if (free_frames() == 0) saw_full = 1'b1;
      end
    end
    pending    <= expected_q.size();
    fail_count <= fails;
    checked    <= results;
    full_seen  <= saw_full;
  end

endmodule

### test/page_frame_table_top_tb.sv
module page_frame_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pft_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 700;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  pft_in_t  in_data = '0;
  logic     busy;
  logic     out_valid;
  pft_out_t out_data;

  int   fail_count;
  int   pending;
  int   checked;
  logic full_seen;

  int op_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  page_frame_table_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  pft_checker frame_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked),
    .full_seen (full_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles with neither an accepted request nor a result
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Random pause after a transaction; zero keeps start high
  task automatic pause_after;
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 50) gap = 0;
    else if (pick < 75) gap = $urandom_range(1, 3);
    else if (pick < 95) gap = $urandom_range(4, 140);
    else gap = $urandom_range(141, 300);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic request(input pft_op_t op, input logic [OWNER_BITS-1:0] owner,
                         input logic [PAGE_BITS-1:0] page,
                         input logic [NEED_W-1:0] need);
    pft_in_t req;
    req.operation   = op;
    req.owner_id    = owner;
    req.page_number = page;
    req.need_count  = need;
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    op_count[op]++;
    pause_after();
  endtask

  // Small owner and page sets so lookups and frees hit often
  function automatic logic [OWNER_BITS-1:0] pick_owner();
    logic [OWNER_BITS-1:0] pool [6];
    pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80};
    if ($urandom_range(0, 9) == 0) return OWNER_BITS'($urandom_range(0, 255));
    return pool[$urandom_range(0, 5)];
  endfunction

  function automatic logic [PAGE_BITS-1:0] pick_page();
    logic [PAGE_BITS-1:0] page;
    if ($urandom_range(0, 9) == 0) return PAGE_BITS'($urandom_range(0, 1023));
    page = PAGE_BITS'($urandom_range(0, 7));
    if ($urandom_range(0, 1) == 1) page = page ^ 10'h3FF;
    return page;
  endfunction

  function automatic logic [NEED_W-1:0] pick_need();
    if ($urandom_range(0, 4) == 0) return NEED_W'($urandom_range(0, 255));
    return NEED_W'($urandom_range(0, FRAMES + 2));
  endfunction

  // Phase 0/3 fills the table, 1 mixes, 2 drains it
  function automatic pft_op_t pick_op(int phase);
    int w;
    w = $urandom_range(0, 99);
    case (phase)
      0, 3: begin
        if (w < 80) return OP_ALLOC;
        else if (w < 92) return OP_LOOKUP;
        else return OP_TEST;
      end
      1: begin
        if (w < 35) return OP_ALLOC;
        else if (w < 70) return OP_LOOKUP;
        else if (w < 80) return OP_FREE;
        else return OP_TEST;
      end
      default: begin
        if (w < 15) return OP_ALLOC;
        else if (w < 45) return OP_LOOKUP;
        else if (w < 80) return OP_FREE;
        else return OP_TEST;
      end
    endcase
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, test limits, duplicates, lowest-frame choice
    request(OP_TEST,   8'h00, 10'h000, 8'd0);
    request(OP_TEST,   8'h00, 10'h000, 8'd128);
    request(OP_TEST,   8'h00, 10'h000, 8'd129);
    request(OP_TEST,   8'hFF, 10'h3FF, 8'd255);
    request(OP_LOOKUP, 8'h00, 10'h000, 8'd0);
    request(OP_FREE,   8'h00, 10'h000, 8'd0);
    request(OP_ALLOC,  8'h00, 10'h000, 8'd0);
    request(OP_ALLOC,  8'hFF, 10'h3FF, 8'hFF);
    request(OP_ALLOC,  8'h00, 10'h000, 8'd0);
    request(OP_LOOKUP, 8'h00, 10'h000, 8'd0);
    request(OP_LOOKUP, 8'hFF, 10'h3FF, 8'd0);
    request(OP_LOOKUP, 8'hFF, 10'h000, 8'd0);
    request(OP_TEST,   8'h00, 10'h000, 8'd125);
    request(OP_TEST,   8'h00, 10'h000, 8'd126);
    request(OP_FREE,   8'h00, 10'h2AA, 8'd0);
    request(OP_LOOKUP, 8'h00, 10'h000, 8'd0);
    request(OP_ALLOC,  8'hA5, 10'h155, 8'd0);
    request(OP_ALLOC,  8'h5A, 10'h2AA, 8'hFF);
    request(OP_TEST,   8'h00, 10'h000, 8'd0);
    request(OP_FREE,   8'hFF, 10'h000, 8'd0);
    request(OP_FREE,   8'hA5, 10'h000, 8'd0);
    request(OP_FREE,   8'h5A, 10'h000, 8'd0);
    request(OP_TEST,   8'h00, 10'h000, 8'd128);

    // Random traffic in phases that fill, mix and drain the table
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      request(pick_op(k / 175), pick_owner(), pick_page(), pick_need());
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (FRAMES + 8) @(posedge clk);

    $display("summary: %0d requests (lookup %0d, allocate %0d, free %0d, test %0d)",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_LOOKUP], op_count[OP_ALLOC], op_count[OP_FREE],
             op_count[OP_TEST]);
    $display("summary: %0d results checked, table completely full %s",
             checked, full_seen ? "at least once" : "never");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
